>>> rtl/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg
// shared types and codes for the shortest queue dispatcher
// ----------------------------------------------------------------------------
package sqd_pkg;

	localparam int OPCODE_W = 2;
	localparam int QIDX_W   = 3;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = 10;

	typedef enum logic [OPCODE_W-1:0] {
		OP_DELIVER = 2'd0,
		OP_TAKE    = 2'd1,
		OP_ATTACH  = 2'd2,
		OP_DETACH  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_WOULD_BLOCK = 2'd1,
		ST_EMPTY       = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_OPRES
	} state_t;

endpackage

>>> rtl/sqd_occ_mem.sv
// ----------------------------------------------------------------------------
// sqd_occ_mem
// occupancy memory, one write and one registered read port per cycle;
// per-entry valid bits make unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module sqd_occ_mem #(
	parameter int AW = 3,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0]    mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	// entry never written since reset reads as zero
	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

>>> rtl/sqd_alu.sv
// ----------------------------------------------------------------------------
// sqd_alu
// shared arithmetic unit: one less-than compare, one zero test and one
// increment/decrement adder, reused by the scan, finish and result steps of the sequencer
// ----------------------------------------------------------------------------
module sqd_alu #(
	parameter int OW = 10
) (
	input  logic [OW-1:0] a,
	input  logic [OW-1:0] b,
	input  logic          dec,
	output logic          lt,
	output logic          zero,
	output logic [OW-1:0] sum
);

	assign lt   = a < b;
	assign zero = a == '0;
	assign sum  = a + (dec ? {OW{1'b1}} : OW'(1));

endmodule

>>> rtl/sqd_ctrl.sv
// ----------------------------------------------------------------------------
// sqd_ctrl
// sequencer: circular shortest-queue scan, take, attach and detach, with
// attached flags, start index and the registered result
// ----------------------------------------------------------------------------
module sqd_ctrl
	import sqd_pkg::*;
#(
	parameter int QUEUE_COUNT    = 8,
	parameter int QUEUE_CAPACITY = 512,
	parameter int AW             = 3,
	parameter int OW             = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [QIDX_W-1:0]   queue_index,
	output logic                busy,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [QIDX_W-1:0]   chosen_queue,
	output logic [DEPTH_W-1:0]  depth_after,
	output logic                readable,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [OW-1:0]       mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  logic [OW-1:0]       mem_rdata
);

	localparam int DEPTH = 1 << AW;
	localparam int CNT_W = $clog2(QUEUE_COUNT + 1);

	state_t              state_q, state_d;
	opcode_t             op_q, op_d;
	logic [QIDX_W-1:0]   qidx_q, qidx_d;
	logic                qvld_q, qvld_d;
	logic [AW-1:0]       scan_idx_q, scan_idx_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                cmp_vld_s1, cmp_vld_d;
	logic [AW-1:0]       cmp_idx_s1, cmp_idx_d;
	logic                cmp_att_s1, cmp_att_d;
	logic                found_q, found_d;
	logic [AW-1:0]       best_q, best_d;
	logic [OW-1:0]       best_len_q, best_len_d;
	logic [AW-1:0]       start_q, start_d;
	logic [DEPTH-1:0]    att_q, att_d;

	logic                done_q;
	status_t             status_q;
	logic [QIDX_W-1:0]   chosen_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                readable_q;

	logic                res_load;
	status_t             res_status;
	logic [QIDX_W-1:0]   res_qidx;
	logic [OW-1:0]       res_depth;

	logic [OW-1:0]       alu_a, alu_b, alu_sum;
	logic                alu_dec, alu_lt, alu_zero;

	logic                issue;
	logic                hit;
	logic [OW-1:0]       occ;
	logic                qvld_in;
	logic [AW-1:0]       qaddr_in, qaddr_q, scan_next;

	assign qvld_in   = 32'(queue_index) < 32'(QUEUE_COUNT);
	assign qaddr_in  = AW'(queue_index);
	assign qaddr_q   = AW'(qidx_q);
	assign scan_next = (scan_idx_q == AW'(QUEUE_COUNT - 1)) ? '0 : scan_idx_q + AW'(1);
	assign issue     = cnt_q != CNT_W'(QUEUE_COUNT);
	assign hit       = cmp_vld_s1 && cmp_att_s1;
	assign occ       = qvld_q ? mem_rdata : '0;

	sqd_alu #(
		.OW(OW)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.dec (alu_dec),
		.lt  (alu_lt),
		.zero(alu_zero),
		.sum (alu_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			start_q    <= '0;
			att_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			cmp_vld_s1 <= cmp_vld_d;
			found_q    <= found_d;
			start_q    <= start_d;
			att_q      <= att_d;
			done_q     <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		qidx_q     <= qidx_d;
		qvld_q     <= qvld_d;
		scan_idx_q <= scan_idx_d;
		cmp_idx_s1 <= cmp_idx_d;
		cmp_att_s1 <= cmp_att_d;
		best_q     <= best_d;
		best_len_q <= best_len_d;
		if (res_load) begin
			status_q   <= res_status;
			chosen_q   <= res_qidx;
			depth_q    <= DEPTH_W'(res_depth);
			readable_q <= res_depth != '0;
		end
	end

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		qidx_d     = qidx_q;
		qvld_d     = qvld_q;
		scan_idx_d = scan_idx_q;
		cnt_d      = cnt_q;
		cmp_vld_d  = 1'b0;
		cmp_idx_d  = cmp_idx_s1;
		cmp_att_d  = cmp_att_s1;
		found_d    = found_q;
		best_d     = best_q;
		best_len_d = best_len_q;
		start_d    = start_q;
		att_d      = att_q;
		mem_we     = 1'b0;
		mem_waddr  = best_q;
		mem_wdata  = alu_sum;
		mem_re     = 1'b0;
		mem_raddr  = scan_idx_q;
		alu_a      = mem_rdata;
		alu_b      = best_len_q;
		alu_dec    = 1'b0;
		res_load   = 1'b0;
		res_status = ST_OK;
		res_qidx   = qidx_q;
		res_depth  = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d       = opcode_t'(opcode);
					qidx_d     = queue_index;
					qvld_d     = qvld_in;
					mem_re     = 1'b1;
					mem_raddr  = qaddr_in;
					scan_idx_d = start_q;
					cnt_d      = '0;
					found_d    = 1'b0;
					best_len_d = '0;
					state_d    = (opcode_t'(opcode) == OP_DELIVER) ? S_SCAN : S_OPRES;
				end
			end
			S_SCAN: begin
				// read one queue per cycle, compare the one read the cycle before
				if (issue) begin
					mem_re     = 1'b1;
					mem_raddr  = scan_idx_q;
					scan_idx_d = scan_next;
					cnt_d      = cnt_q + CNT_W'(1);
					cmp_vld_d  = 1'b1;
					cmp_idx_d  = scan_idx_q;
					cmp_att_d  = att_q[scan_idx_q];
				end
				if (hit && alu_zero) begin
					found_d    = 1'b1;
					best_d     = cmp_idx_s1;
					best_len_d = '0;
					cmp_vld_d  = 1'b0;
					state_d    = S_FINISH;
				end else begin
					if (hit && (!found_q || alu_lt)) begin
						found_d    = 1'b1;
						best_d     = cmp_idx_s1;
						best_len_d = mem_rdata;
					end
					if (!issue) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				alu_a    = best_len_q;
				alu_b    = OW'(QUEUE_CAPACITY);
				res_load = 1'b1;
				state_d  = S_IDLE;
				if (!found_q) begin
					res_status = ST_WOULD_BLOCK;
					res_qidx   = '0;
				end else if (alu_lt) begin
					mem_we     = 1'b1;
					mem_waddr  = best_q;
					start_d    = best_q;
					res_qidx   = QIDX_W'(best_q);
					res_depth  = alu_sum;
				end else begin
					res_status = ST_WOULD_BLOCK;
					res_qidx   = QIDX_W'(best_q);
					res_depth  = best_len_q;
				end
			end
			S_OPRES: begin
				alu_a    = occ;
				alu_dec  = 1'b1;
				res_load = 1'b1;
				state_d  = S_IDLE;
				case (op_q)
					OP_TAKE: begin
						if (alu_zero) begin
							res_status = ST_EMPTY;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = qaddr_q;
							res_depth = alu_sum;
						end
					end
					OP_ATTACH, OP_DETACH: begin
						if (qvld_q) begin
							att_d[qaddr_q] = op_q == OP_ATTACH;
						end
						res_depth = occ;
					end
					default: begin
						res_depth = occ;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign status       = status_q;
	assign chosen_queue = chosen_q;
	assign depth_after  = depth_q;
	assign readable     = readable_q;

endmodule

>>> rtl/shortest_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher
// join-shortest-queue dispatch of packets onto a set of receive queues
// ----------------------------------------------------------------------------
// deliver: circular scan of the queues from the start index, bound by one memory
//   read a cycle; an empty attached queue ends the scan early; a new start is
//   taken only once the block is idle again
// take, attach, detach: occupancy read on the start transfer, then the result state
// the result strobe lasts one cycle and cannot be held off by the receiver
// arst_n clears occupancy (valid bits), attached flags and the start index
module shortest_queue_dispatcher
	import sqd_pkg::*;
#(
	parameter int QUEUE_COUNT    = 8,
	parameter int QUEUE_CAPACITY = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [QIDX_W-1:0]   queue_index,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [QIDX_W-1:0]   chosen_queue,
	output logic [DEPTH_W-1:0]  depth_after,
	output logic                readable
);

	// queue address width and occupancy counter width
	localparam int AW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int OW = $clog2(QUEUE_CAPACITY + 1);

	// occupancy memory port signals between sequencer and storage
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [OW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [OW-1:0] mem_rdata;

	// sequencer: owns flags, start index, scan state and result register
	sqd_ctrl #(
		.QUEUE_COUNT   (QUEUE_COUNT),
		.QUEUE_CAPACITY(QUEUE_CAPACITY),
		.AW            (AW),
		.OW            (OW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.queue_index (queue_index),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.chosen_queue(chosen_queue),
		.depth_after (depth_after),
		.readable    (readable),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// per-queue occupancy counts, read data registered
	sqd_occ_mem #(
		.AW(AW),
		.DW(OW)
	) u_occ_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

>>> rtl/sqd_checker.sv
// ----------------------------------------------------------------------------
// sqd_port_checks
// port-level checks of the dispatcher, attached by bind
// ----------------------------------------------------------------------------
module sqd_port_checks
	import sqd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [DEPTH_W-1:0]  depth_after,
	input logic                readable
);

	// an accepted start keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	// a result only shows once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// results never come in adjacent cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// an empty take reports nothing held
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> depth_after == '0 && !readable)
		else $error("empty take reports occupancy");

	// an unreadable queue has no occupancy
	a_readable: assert property (@(posedge clk) disable iff (!arst_n)
		done && !readable |-> depth_after == '0)
		else $error("readable flag disagrees with depth");

endmodule

bind shortest_queue_dispatcher sqd_port_checks u_sqd_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.depth_after(depth_after),
	.readable   (readable)
);
